>>> sv/mts_pkg.sv
// Package for the min-tracking stack: sizes, operation codes and controller states.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ENTRY_W     = 9;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } mts_state_t;

endpackage
`default_nettype wire

>>> sv/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/min_tracking_stack_unit.sv
// Top level of the min-tracking stack: controller, cached tops and the two stores.
//
// Usage
//   Command channel: drive func / push_value with start high; the command is
//   transferred at the rising edge where start is high and busy is low.
//   func = push places push_value on the stack, func = pop removes the top.
//   Result channel: one result per command, shown for exactly one cycle with
//   done high; top_value, min_value, not_empty, entry_count and rejected
//   describe the stack after the command. The receiver cannot stall it.
//   A push on a full stack or a pop on an empty one leaves the stack alone
//   and returns rejected = 1. Top and minimum read zero on an empty stack.
// Timing
//   Push and rejected commands: result in the cycle after the transfer, busy
//   stays low, so these run one per cycle.
//   Pop: result after the ST_READ state, busy high for one cycle while
//   the new top entries come back from the value and minimum RAMs
//   (registered read data). Sustained rate is one command per cycle for
//   pushes; a pop holds off the next command while busy is high.
// Reset
//   rst (synchronous) empties the stack; RAM contents are not cleared since
//   only entries below the counts are ever read.
`timescale 1ns / 1ps
`default_nettype none
module min_tracking_stack_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               func,
  input  wire logic signed [mts_pkg::DATA_W-1:0]  push_value,
  output logic                                    done,
  output logic signed      [mts_pkg::DATA_W-1:0]  top_value,
  output logic signed      [mts_pkg::DATA_W-1:0]  min_value,
  output logic                                    not_empty,
  output logic             [mts_pkg::ENTRY_W-1:0] entry_count,
  output logic                                    rejected
);

  localparam int DW = mts_pkg::DATA_W;
  localparam int CW = mts_pkg::COUNT_W;
  localparam int AW = mts_pkg::ADDR_W;

  // Controller state and cached top entries of both stores.
  mts_pkg::mts_state_t  state, state_next;
  logic [CW-1:0]        vcount, vcount_next;
  logic [CW-1:0]        mcount, mcount_next;
  logic signed [DW-1:0] top_reg, top_reg_next;
  logic signed [DW-1:0] min_reg, min_reg_next;

  // Result register.
  logic                 done_next;
  logic signed [DW-1:0] top_value_next, min_value_next;
  logic                 not_empty_next, rejected_next;
  logic [mts_pkg::ENTRY_W-1:0] entry_count_next;

  // RAM ports.
  logic          v_we, m_we, rd_en;
  logic [AW-1:0] v_waddr, m_waddr, v_raddr, m_raddr;
  logic [DW-1:0] v_rdata, m_rdata;

  logic accept, is_full, is_empty, min_take;

  assign busy     = (state == mts_pkg::ST_READ);
  assign accept   = start && !busy;
  assign is_full  = (vcount == CW'(mts_pkg::STACK_DEPTH));
  assign is_empty = (vcount == '0);
  // Push records a new minimum when it is <= the current one (duplicates kept).
  assign min_take = (mcount == '0) || (push_value <= min_reg);

  always_comb begin
    state_next       = state;
    vcount_next      = vcount;
    mcount_next      = mcount;
    top_reg_next     = top_reg;
    min_reg_next     = min_reg;
    done_next        = 1'b0;
    top_value_next   = top_value;
    min_value_next   = min_value;
    not_empty_next   = not_empty;
    entry_count_next = entry_count;
    rejected_next    = rejected;
    v_we             = 1'b0;
    m_we             = 1'b0;
    rd_en            = 1'b0;
    v_waddr          = AW'(vcount);
    m_waddr          = AW'(mcount);
    v_raddr          = '0;
    m_raddr          = '0;
    case (state)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          if ((func == mts_pkg::FUNC_PUSH && is_full) ||
              (func == mts_pkg::FUNC_POP && is_empty)) begin
            // Ignored command: report the unchanged stack.
            top_value_next   = is_empty ? '0 : top_reg;
            min_value_next   = (is_empty || mcount == '0) ? '0 : min_reg;
            not_empty_next   = !is_empty;
            entry_count_next = mts_pkg::ENTRY_W'(vcount);
            rejected_next    = 1'b1;
          end else if (func == mts_pkg::FUNC_PUSH) begin
            v_we             = 1'b1;
            vcount_next      = vcount + CW'(1);
            top_reg_next     = push_value;
            top_value_next   = push_value;
            min_value_next   = min_take ? push_value : min_reg;
            not_empty_next   = 1'b1;
            entry_count_next = mts_pkg::ENTRY_W'(vcount + CW'(1));
            rejected_next    = 1'b0;
            if (min_take) begin
              m_we         = 1'b1;
              mcount_next  = mcount + CW'(1);
              min_reg_next = push_value;
            end
          end else begin
            // Pop: drop the cached tops, fetch the entries below them.
            done_next   = 1'b0;
            vcount_next = vcount - CW'(1);
            if (mcount != '0 && top_reg == min_reg) begin
              mcount_next = mcount - CW'(1);
            end
            rd_en      = 1'b1;
            v_raddr    = AW'(vcount_next - CW'(1));
            m_raddr    = AW'(mcount_next - CW'(1));
            state_next = mts_pkg::ST_READ;
          end
        end
      end
      mts_pkg::ST_READ: begin
        top_reg_next     = v_rdata;
        min_reg_next     = m_rdata;
        top_value_next   = is_empty ? '0 : v_rdata;
        min_value_next   = (is_empty || mcount == '0) ? '0 : m_rdata;
        not_empty_next   = !is_empty;
        entry_count_next = mts_pkg::ENTRY_W'(vcount);
        rejected_next    = 1'b0;
        done_next        = 1'b1;
        state_next       = mts_pkg::ST_IDLE;
      end
      default: begin
        state_next = mts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mts_pkg::ST_IDLE;
      vcount <= '0;
      mcount <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      vcount <= vcount_next;
      mcount <= mcount_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    top_reg     <= top_reg_next;
    min_reg     <= min_reg_next;
    top_value   <= top_value_next;
    min_value   <= min_value_next;
    not_empty   <= not_empty_next;
    entry_count <= entry_count_next;
    rejected    <= rejected_next;
  end

  // Pops never write and a write lands before any later read is issued,
  // so the stores need no forwarding.
  mts_ram #(
    .WIDTH(DW),
    .DEPTH(mts_pkg::STACK_DEPTH)
  ) u_value_ram (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(push_value),
    .re   (rd_en),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  mts_ram #(
    .WIDTH(DW),
    .DEPTH(mts_pkg::STACK_DEPTH)
  ) u_min_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(push_value),
    .re   (rd_en),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

`ifndef SYNTHESIS
  // Minimum store never holds more entries than the value store.
  a_min_le_count: assert property (@(posedge clk) disable iff (rst)
    mcount <= vcount)
    else $error("min count exceeds value count");

  // A non-empty stack always has a recorded minimum.
  a_min_present: assert property (@(posedge clk) disable iff (rst)
    (vcount != '0) |-> (mcount != '0))
    else $error("non-empty stack without minimum");

  // Accepted push or rejected command answers in the next cycle.
  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == mts_pkg::FUNC_PUSH || is_empty)) |=> done)
    else $error("missing result after push or reject");

  // Accepted pop answers once ST_READ has passed, with done low in between.
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (accept && func == mts_pkg::FUNC_POP && !is_empty) |=> (!done ##1 done))
    else $error("pop result timing wrong");

  // Reported flag agrees with the reported count.
  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (not_empty == (entry_count != '0)))
    else $error("not_empty disagrees with entry_count");
`endif

endmodule
`default_nettype wire
